/* rtl/msl_pkg.sv */
// Shared constants and types for the median, slew-limit and low-pass filter chain.
package msl_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int SLEW_FRAC   = 8;

    localparam int STEP_W     = SAMPLE_BITS + SLEW_FRAC;
    localparam int WEIGHT_W   = WEIGHT_BITS + 1;
    localparam int SMOOTH_W   = SAMPLE_BITS + WEIGHT_BITS;
    localparam int CFG_DATA_W = (WEIGHT_W > STEP_W) ? WEIGHT_W : STEP_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(1) << WEIGHT_BITS;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(1) << (WEIGHT_BITS - 2);
    localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(1) << (STEP_W - 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTHING_WEIGHT = 1'b0,
        CFG_MAX_STEP         = 1'b1
    } t_cfg_idx;

endpackage

/* rtl/msl_median.sv */
// Three-point median stage with pass-through while the history fills.
module msl_median (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  msl_pkg::t_sample i_sample,
    input  logic             i_ready_next,
    output logic             o_ready,
    output logic             o_valid,
    output msl_pkg::t_sample o_sample
);

    function automatic msl_pkg::t_sample mid3(input msl_pkg::t_sample a,
                                              input msl_pkg::t_sample b,
                                              input msl_pkg::t_sample c);
        msl_pkg::t_sample lo;
        msl_pkg::t_sample hi;
        msl_pkg::t_sample hc;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        hc = (hi < c) ? hi : c;
        return (lo > hc) ? lo : hc;
    endfunction

    logic             r_valid;
    msl_pkg::t_sample r_sample;
    msl_pkg::t_sample r_hist0;
    msl_pkg::t_sample r_hist1;
    logic [1:0]       r_fill;
    logic [1:0]       n_fill;
    msl_pkg::t_sample n_sample;
    logic             take;

    assign o_ready  = !r_valid || i_ready_next;
    assign take     = i_valid && o_ready;
    assign n_fill   = (r_fill == 2'd3) ? r_fill : r_fill + 2'd1;
    // pass the sample through until two samples are in the history
    assign n_sample = (r_fill < 2'd2) ? i_sample : mid3(i_sample, r_hist0, r_hist1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fill  <= 2'd0;
            r_hist0 <= '0;
            r_hist1 <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (take) begin
                r_fill  <= n_fill;
                r_hist1 <= r_hist0;
                r_hist0 <= i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sample <= n_sample;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

/* rtl/msl_slew.sv */
// Slew-rate limiter stage with an 8-fraction-bit level.
module msl_slew (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [msl_pkg::STEP_W-1:0] i_max_step,
    input  logic                       i_valid,
    input  msl_pkg::t_sample           i_sample,
    input  logic                       i_ready_next,
    output logic                       o_ready,
    output logic                       o_valid,
    output msl_pkg::t_sample           o_sample
);

    localparam int LW = msl_pkg::STEP_W;
    localparam int DW = LW + 2;

    logic                 r_valid;
    msl_pkg::t_sample     r_sample;
    logic                 r_primed;
    logic signed [LW-1:0] r_level;
    logic signed [LW-1:0] target;
    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] lim;
    logic signed [DW-1:0] neg_lim;
    logic signed [DW-1:0] step;
    logic signed [DW-1:0] sum;
    logic signed [LW-1:0] moved;
    logic signed [LW-1:0] quo;
    logic signed [LW-1:0] quo_adj;
    logic                 rnd;
    logic signed [LW-1:0] n_level;
    msl_pkg::t_sample     n_sample;
    logic                 take;

    assign o_ready = !r_valid || i_ready_next;
    assign take    = i_valid && o_ready;

    assign target  = $signed({i_sample, {msl_pkg::SLEW_FRAC{1'b0}}});
    assign diff    = DW'(target) - DW'(r_level);
    assign lim     = $signed({2'b00, i_max_step});
    assign neg_lim = -lim;
    // clamp the move to the allowed step in either direction
    assign step    = (diff > lim) ? lim : ((diff < neg_lim) ? neg_lim : diff);
    assign sum     = DW'(r_level) + step;
    assign moved   = sum[LW-1:0];

    // truncate toward zero: round a negative level with a fraction up by one
    assign quo     = moved >>> msl_pkg::SLEW_FRAC;
    assign rnd     = moved[LW-1] && (|moved[msl_pkg::SLEW_FRAC-1:0]);
    assign quo_adj = quo + $signed({{(LW-1){1'b0}}, rnd});

    assign n_level  = r_primed ? moved : target;
    assign n_sample = r_primed ? quo_adj[msl_pkg::SAMPLE_BITS-1:0] : i_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_primed <= 1'b0;
            r_level  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (take) begin
                r_primed <= 1'b1;
                r_level  <= n_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sample <= n_sample;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

/* rtl/msl_lowpass.sv */
// First-order low-pass stage with a Q1.16 weight and a 16-fraction-bit level.
module msl_lowpass (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [msl_pkg::WEIGHT_W-1:0] i_weight,
    input  logic                         i_valid,
    input  msl_pkg::t_sample             i_sample,
    input  logic                         i_ready_next,
    output logic                         o_ready,
    output logic                         o_valid,
    output msl_pkg::t_sample             o_sample
);

    localparam int LW = msl_pkg::SMOOTH_W;
    localparam int WB = msl_pkg::WEIGHT_BITS;
    localparam int PW = msl_pkg::WEIGHT_W + 1 + LW + 1;
    localparam int NW = PW + 1;

    logic                               r_valid;
    msl_pkg::t_sample                   r_sample;
    logic                               r_primed;
    logic signed [LW-1:0]               r_level;
    logic [msl_pkg::WEIGHT_W-1:0]       w_sat;
    logic signed [msl_pkg::WEIGHT_W:0]  w_s;
    logic signed [LW-1:0]               target;
    logic signed [LW:0]                 diff;
    logic signed [PW-1:0]               prod;
    logic signed [NW-1:0]               num;
    logic signed [NW-1:0]               num_q;
    logic signed [NW-1:0]               num_adj;
    logic                               num_rnd;
    logic signed [LW-1:0]               moved;
    logic signed [LW-1:0]               quo;
    logic signed [LW-1:0]               quo_adj;
    logic                               rnd;
    logic signed [LW-1:0]               n_level;
    msl_pkg::t_sample                   n_sample;
    logic                               take;

    assign o_ready = !r_valid || i_ready_next;
    assign take    = i_valid && o_ready;

    // saturate the weight at 1.0
    assign w_sat  = (i_weight > msl_pkg::WEIGHT_ONE) ? msl_pkg::WEIGHT_ONE : i_weight;
    assign w_s    = $signed({1'b0, w_sat});
    assign target = $signed({i_sample, {WB{1'b0}}});
    assign diff   = (LW+1)'(target) - (LW+1)'(r_level);

    // level*one + w*(target - level), then divide by one toward zero
    assign prod    = PW'(w_s) * PW'(diff);
    assign num     = (NW'(r_level) <<< WB) + NW'(prod);
    assign num_q   = num >>> WB;
    assign num_rnd = num[NW-1] && (|num[WB-1:0]);
    assign num_adj = num_q + $signed({{(NW-1){1'b0}}, num_rnd});
    assign moved   = num_adj[LW-1:0];

    assign quo     = moved >>> WB;
    assign rnd     = moved[LW-1] && (|moved[WB-1:0]);
    assign quo_adj = quo + $signed({{(LW-1){1'b0}}, rnd});

    assign n_level  = r_primed ? moved : target;
    assign n_sample = r_primed ? quo_adj[msl_pkg::SAMPLE_BITS-1:0] : i_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_primed <= 1'b0;
            r_level  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (take) begin
                r_primed <= 1'b1;
                r_level  <= n_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sample <= n_sample;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

/* rtl/median_slew_lowpass_chain_top.sv */
// Top level of the median, slew-limit and low-pass filter chain.
//
//  channel | valid    | stall    | payload
//  --------+----------+----------+-----------------------------
//  input   | i_valid  | o_stall  | i_sample_in   (16b signed)
//  output  | o_valid  | i_stall  | o_sample_out  (16b signed)
//  config  | i_cfg_we | -        | i_cfg_idx, i_cfg_data (24b)
//
// One word in, one word out. A word leaves through the median, slew and
// low-pass registers, and a new word may be accepted in every cycle while
// o_stall is low; the low-pass multiply-add in its level loop sets the
// cycle time.
// Reset is synchronous and active low; it clears all filter state and loads
// the reset register values. No clearing pass is needed.
// A stall on the output backs up stage by stage; empty stages keep filling,
// so up to three words are held before o_stall rises.
module median_slew_lowpass_chain_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [15:0]             i_sample_in,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [15:0]             o_sample_out,
    input  logic                           i_cfg_we,
    input  logic [msl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [msl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [msl_pkg::WEIGHT_W-1:0] r_smoothing_weight;
    logic [msl_pkg::STEP_W-1:0]   r_max_step;

    // stage handshakes
    logic             med_ready;
    logic             med_valid;
    msl_pkg::t_sample med_sample;
    logic             slew_ready;
    logic             slew_valid;
    msl_pkg::t_sample slew_sample;
    logic             lp_ready;

    // load a register on a write; data beyond the register width is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smoothing_weight <= msl_pkg::WEIGHT_RESET;
            r_max_step         <= msl_pkg::STEP_RESET;
        end else if (i_cfg_we) begin
            case (msl_pkg::t_cfg_idx'(i_cfg_idx))
                msl_pkg::CFG_SMOOTHING_WEIGHT: begin
                    r_smoothing_weight <= i_cfg_data[msl_pkg::WEIGHT_W-1:0];
                end
                msl_pkg::CFG_MAX_STEP: begin
                    r_max_step <= i_cfg_data[msl_pkg::STEP_W-1:0];
                end
                default: begin
                    r_max_step <= r_max_step;
                end
            endcase
        end
    end

    // stage one: median of the last three samples
    msl_median u_median (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_sample     (i_sample_in),
        .i_ready_next (slew_ready),
        .o_ready      (med_ready),
        .o_valid      (med_valid),
        .o_sample     (med_sample)
    );

    // stage two: limit the level change per word
    msl_slew u_slew (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_step   (r_max_step),
        .i_valid      (med_valid),
        .i_sample     (med_sample),
        .i_ready_next (lp_ready),
        .o_ready      (slew_ready),
        .o_valid      (slew_valid),
        .o_sample     (slew_sample)
    );

    // stage three: low-pass; its register is the output register
    msl_lowpass u_lowpass (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_weight     (r_smoothing_weight),
        .i_valid      (slew_valid),
        .i_sample     (slew_sample),
        .i_ready_next (!i_stall),
        .o_ready      (lp_ready),
        .o_valid      (o_valid),
        .o_sample     (o_sample_out)
    );

    // hold off the source only when the median register cannot move on
    assign o_stall = !med_ready;

endmodule

/* rtl/msl_checker.sv */
// Port-level checks for the filter chain, bound to its top level.
module msl_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic signed [15:0]             i_sample_in,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic signed [15:0]             o_sample_out,
    input logic                           i_cfg_we,
    input logic [msl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [msl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // no word is shown right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid after reset");

    // a word waiting on a stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample_out))
        else $error("stalled output word changed");

    // the input is only held off by back-pressure from the output
    a_no_spurious_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output drains");

    // an accepted word reaches the output through the median, slew and low-pass registers when nothing stalls
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_stall) ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("accepted word did not reach the output");

endmodule

bind median_slew_lowpass_chain_top msl_checker u_msl_checker (.*);
